// ===== hw/rtl/rsad_pkg.sv =====
// Shared types, constants and key compare for the age/name record sorter.
package rsad_pkg;

	localparam int MAX_RECORDS_DEF = 8;
	localparam int NAME_BYTES_DEF  = 30;

	localparam int AGE_W       = 8;
	localparam int IDX_W       = 3;
	localparam int WORD_W      = 64;
	localparam int TAIL_W      = 48;
	localparam int NAME_FIELDS = 30;
	localparam int NAME_W      = 8 * NAME_FIELDS;

	typedef struct packed {
		logic [WORD_W-1:0] name_bytes_a;
		logic [WORD_W-1:0] name_bytes_b;
		logic [WORD_W-1:0] name_bytes_c;
		logic [TAIL_W-1:0] name_bytes_d;
		logic [AGE_W-1:0]  age_years;
		logic              last_record;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]  original_index;
		logic [AGE_W-1:0]  sorted_age;
		logic [WORD_W-1:0] out_name_a;
		logic [WORD_W-1:0] out_name_b;
		logic [WORD_W-1:0] out_name_c;
		logic [TAIL_W-1:0] out_name_d;
		logic              last_result;
		logic              overflow_seen;
	} out_item_t;

	// One stored record; name is the four words concatenated, byte 0 on top.
	typedef struct packed {
		logic [AGE_W-1:0]  age;
		logic [NAME_W-1:0] name;
		logic [IDX_W-1:0]  idx;
	} rec_t;

	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctl_t;

	// Keeps the name bytes that lie below the configured name length.
	function automatic logic [NAME_W-1:0] name_mask(input int nb);
		logic [NAME_W-1:0] m;
		m = '0;
		for (int k = 0; k < NAME_FIELDS; k++) begin
			if (k < nb) begin
				m[NAME_W-1-8*k -: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

	// True when the held record sorts strictly behind the arriving one:
	// lower age, or equal age and a greater name.
	function automatic logic goes_after(input rec_t held, input rec_t arrival);
		return {~held.age, held.name} > {~arrival.age, arrival.name};
	endfunction

endpackage

// ===== hw/rtl/rsad_in_if.sv =====
// Valid/ready channel that carries one input record per beat.
interface rsad_in_if;
	logic               valid;
	logic               ready;
	rsad_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rsad_out_if.sv =====
// Valid/ready channel that carries one sorted result per beat.
interface rsad_out_if;
	logic                valid;
	logic                ready;
	rsad_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rsad_cell.sv =====
// One slot of the insertion chain: holds a record, compares and hands it on.
module rsad_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  rsad_pkg::cell_ctl_t ctl,
	input  rsad_pkg::rec_t     new_rec,
	input  rsad_pkg::rec_t     left_rec,
	input  logic               left_valid,
	input  logic               left_gt,
	input  rsad_pkg::rec_t     right_rec,
	input  logic               right_valid,
	output rsad_pkg::rec_t     rec,
	output logic               valid,
	output logic               gt
);
	import rsad_pkg::*;

	rec_t rec_q;
	logic valid_q;

	// An empty slot counts as behind everything, so the chain fills in order.
	assign gt    = !valid_q || goes_after(rec_q, new_rec);
	assign rec   = rec_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= right_valid;
		end else if (ctl.insert && gt) begin
			valid_q <= left_gt ? left_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			rec_q <= right_rec;
		end else if (ctl.insert && gt) begin
			rec_q <= left_gt ? left_rec : new_rec;
		end
	end

endmodule

// ===== hw/rtl/record_sorter_age_desc_name_asc.sv =====
// Stable record sorter (age descending, name ascending) built as an insertion chain.
//
// Records arrive on the "records" channel, one per beat. Each accepted record
// is placed into its sorted slot of a chain of MAX_RECORDS cells in the cycle
// it is accepted: every cell compares its record with the arriving one and
// either keeps it, takes its left neighbor's record or takes the new one.
// Equal keys stay in arrival order. Records beyond MAX_RECORDS are dropped and
// the set is flagged with overflow_seen.
// A beat with last_record set is inserted like the others and then starts the
// drain: the chain shifts toward cell 0, which drives the "sorted" channel, one
// result per stored record, last_result on the final one. Input accepts one
// record per cycle while loading; it holds ready low during a drain, which
// moves on whenever the receiver is ready. A stalled receiver simply freezes
// the chain. The first result appears the cycle after the last record is
// accepted. Reset empties the chain and clears the overflow flag.
module record_sorter_age_desc_name_asc #(
	parameter int MAX_RECORDS = rsad_pkg::MAX_RECORDS_DEF,
	parameter int NAME_BYTES  = rsad_pkg::NAME_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rsad_in_if.sink    records,
	rsad_out_if.source sorted
);
	import rsad_pkg::*;

	localparam int CNT_W = $clog2(MAX_RECORDS + 1);
	localparam logic [NAME_W-1:0] NAME_KEEP = name_mask(NAME_BYTES);

	rec_t             cell_rec [MAX_RECORDS];
	logic             cell_valid [MAX_RECORDS];
	logic             cell_gt [MAX_RECORDS];
	rec_t             left_rec [MAX_RECORDS];
	logic             left_valid [MAX_RECORDS];
	logic             left_gt [MAX_RECORDS];
	rec_t             right_rec [MAX_RECORDS];
	logic             right_valid [MAX_RECORDS];

	logic [CNT_W-1:0] count_q;
	logic             dropped_q;
	logic             draining_q;
	logic             in_fire;
	logic             out_fire;
	logic             full;
	logic             last_out;
	rec_t             new_rec;
	cell_ctl_t        ctl;

	assign records.ready = !draining_q;
	assign in_fire  = records.valid && records.ready;
	assign full     = (count_q == CNT_W'(MAX_RECORDS));
	assign last_out = !cell_valid[1];
	assign out_fire = sorted.valid && sorted.ready;

	assign new_rec.age  = records.data.age_years;
	assign new_rec.name = {records.data.name_bytes_a, records.data.name_bytes_b,
		records.data.name_bytes_c, records.data.name_bytes_d} & NAME_KEEP;
	assign new_rec.idx  = IDX_W'(count_q);

	assign ctl.insert = in_fire && !full;
	assign ctl.shift  = out_fire;

	genvar i;
	generate
		for (i = 0; i < MAX_RECORDS; i++) begin : g_cell
			if (i == 0) begin : g_head
				assign left_rec[i]   = new_rec;
				assign left_valid[i] = 1'b0;
				assign left_gt[i]    = 1'b0;
			end else begin : g_mid
				assign left_rec[i]   = cell_rec[i-1];
				assign left_valid[i] = cell_valid[i-1];
				assign left_gt[i]    = cell_gt[i-1];
			end
			if (i == MAX_RECORDS - 1) begin : g_tail
				assign right_rec[i]   = cell_rec[i];
				assign right_valid[i] = 1'b0;
			end else begin : g_body
				assign right_rec[i]   = cell_rec[i+1];
				assign right_valid[i] = cell_valid[i+1];
			end

			rsad_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (ctl),
				.new_rec     (new_rec),
				.left_rec    (left_rec[i]),
				.left_valid  (left_valid[i]),
				.left_gt     (left_gt[i]),
				.right_rec   (right_rec[i]),
				.right_valid (right_valid[i]),
				.rec         (cell_rec[i]),
				.valid       (cell_valid[i]),
				.gt          (cell_gt[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			dropped_q  <= 1'b0;
			draining_q <= 1'b0;
		end else if (draining_q) begin
			if (out_fire && last_out) begin
				count_q    <= '0;
				dropped_q  <= 1'b0;
				draining_q <= 1'b0;
			end
		end else if (in_fire) begin
			if (full) begin
				dropped_q <= 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
			end
			draining_q <= records.data.last_record;
		end
	end

	assign sorted.valid               = draining_q && cell_valid[0];
	assign sorted.data.original_index = cell_rec[0].idx;
	assign sorted.data.sorted_age     = cell_rec[0].age;
	assign sorted.data.out_name_a     = cell_rec[0].name[NAME_W-1 -: WORD_W];
	assign sorted.data.out_name_b     = cell_rec[0].name[NAME_W-1-WORD_W -: WORD_W];
	assign sorted.data.out_name_c     = cell_rec[0].name[NAME_W-1-2*WORD_W -: WORD_W];
	assign sorted.data.out_name_d     = cell_rec[0].name[TAIL_W-1:0];
	assign sorted.data.last_result    = last_out;
	assign sorted.data.overflow_seen  = dropped_q;

	a_no_load_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		sorted.valid |-> !records.ready)
		else $error("input accepted while results are pending");

	a_head_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		(sorted.valid && cell_valid[1]) |-> !goes_after(cell_rec[0], cell_rec[1]))
		else $error("chain head out of sorted order");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && last_out) |=> (count_q == '0 && !cell_valid[0] && !dropped_q))
		else $error("chain not empty after final result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RECORDS))
		else $error("record count beyond capacity");

endmodule

// ===== sim/tb_record_sorter_age_desc_name_asc.sv =====
// Self-checking testbench for the age-descending, name-ascending record sorter.
module tb_record_sorter_age_desc_name_asc;
	timeunit 1ns;
	timeprecision 1ps;

	import rsad_pkg::*;

	localparam int STORE_DEPTH  = MAX_RECORDS_DEF;
	localparam int NAME_LEN     = NAME_BYTES_DEF;
	localparam int RANDOM_RECS  = 200;
	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_GUARD  = 12;
	localparam int CYCLE_LIMIT  = 60000;

	typedef struct packed {
		bit [AGE_W-1:0]  age;
		bit [WORD_W-1:0] na;
		bit [WORD_W-1:0] nb;
		bit [WORD_W-1:0] nc;
		bit [TAIL_W-1:0] nd;
		bit [IDX_W-1:0]  idx;
	} held_rec_t;

	typedef struct {
		in_item_t  rec;
		bit        typed;
		out_item_t want;
	} plan_row_t;

	logic clk;
	logic arst_n;

	rsad_in_if  rec_if ();
	rsad_out_if srt_if ();

	record_sorter_age_desc_name_asc dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.records (rec_if),
		.sorted  (srt_if)
	);

	// Predicted contents of the sorting store.
	held_rec_t sort_store [STORE_DEPTH];
	int        stored_cnt;
	bit        lost_any;

	out_item_t pending_sorted [$];
	plan_row_t plan [$];

	int        err_cnt;
	int        cycles;
	int        recs_sent;
	int        sets_closed;
	int        overflow_sets;
	int        results_checked;
	bit        no_idle;
	bit [239:0] prev_name;
	bit [7:0]   prev_age;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_sorted.size());
			$display("tb_record_sorter_age_desc_name_asc: done, errors");
			$finish;
		end
	end

	task automatic flag_error(string msg);
		err_cnt++;
		$display("%0t ERROR %s", $realtime, msg);
	endtask

	task automatic field_check(string field, logic [63:0] got, logic [63:0] want);
		if (got !== want) begin
			flag_error($sformatf("result %0d %s: got %h want %h", results_checked, field,
				got, want));
		end
	endtask

	function automatic bit [63:0] keep_name(bit [63:0] w, int first, int len);
		bit [63:0] k;
		k = '0;
		for (int i = 0; i < len; i++) begin
			if (first + i < NAME_LEN) begin
				k[8*(len-1-i) +: 8] = 8'hFF;
			end
		end
		return w & k;
	endfunction

	// Held entry h moves behind the arrival n: lower age, or same age and a greater name.
	function automatic bit sorts_behind(held_rec_t h, held_rec_t n);
		if (h.age != n.age) begin
			return h.age < n.age;
		end
		return {h.na, h.nb, h.nc, h.nd} > {n.na, n.nb, n.nc, n.nd};
	endfunction

	// Inserts one accepted record; with emit set, a closing record queues the sorted run.
	function automatic void file_record(in_item_t r, bit emit);
		held_rec_t nr;
		int        j;
		out_item_t res;
		nr.age = r.age_years;
		nr.na  = keep_name(r.name_bytes_a, 0, 8);
		nr.nb  = keep_name(r.name_bytes_b, 8, 8);
		nr.nc  = keep_name(r.name_bytes_c, 16, 8);
		nr.nd  = TAIL_W'(keep_name(64'(r.name_bytes_d), 24, 6));
		nr.idx = IDX_W'(stored_cnt);
		if (stored_cnt < STORE_DEPTH) begin
			j = stored_cnt;
			while (j > 0 && sorts_behind(sort_store[j-1], nr)) begin
				sort_store[j] = sort_store[j-1];
				j--;
			end
			sort_store[j] = nr;
			stored_cnt++;
		end else begin
			lost_any = 1'b1;
		end
		if (!r.last_record) begin
			return;
		end
		sets_closed++;
		if (lost_any) begin
			overflow_sets++;
		end
		if (emit) begin
			for (int k = 0; k < stored_cnt; k++) begin
				res.original_index = sort_store[k].idx;
				res.sorted_age     = sort_store[k].age;
				res.out_name_a     = sort_store[k].na;
				res.out_name_b     = sort_store[k].nb;
				res.out_name_c     = sort_store[k].nc;
				res.out_name_d     = sort_store[k].nd;
				res.last_result    = (k == stored_cnt - 1);
				res.overflow_seen  = lost_any;
				pending_sorted.push_back(res);
			end
		end
		stored_cnt = 0;
		lost_any   = 1'b0;
	endfunction

	function automatic in_item_t mk_rec(bit [63:0] a, bit [63:0] b, bit [63:0] c,
		bit [47:0] d, bit [7:0] age, bit last);
		in_item_t r;
		r.name_bytes_a = a;
		r.name_bytes_b = b;
		r.name_bytes_c = c;
		r.name_bytes_d = d;
		r.age_years    = age;
		r.last_record  = last;
		return r;
	endfunction

	function automatic out_item_t mk_res(bit [2:0] idx, bit [7:0] age, bit [63:0] a,
		bit [63:0] b, bit [63:0] c, bit [47:0] d, bit lastr, bit ovf);
		out_item_t o;
		o.original_index = idx;
		o.sorted_age     = age;
		o.out_name_a     = a;
		o.out_name_b     = b;
		o.out_name_c     = c;
		o.out_name_d     = d;
		o.last_result    = lastr;
		o.overflow_seen  = ovf;
		return o;
	endfunction

	// Offers one record; entered and left at a falling edge.
	task automatic send_rec(in_item_t r, bit typed, out_item_t want);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			rec_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rec_if.valid <= 1'b1;
		rec_if.data  <= r;
		@(posedge clk);
		while (!rec_if.ready) @(posedge clk);
		recs_sent++;
		file_record(r, !typed);
		if (typed) begin
			pending_sorted.push_back(want);
		end
		@(negedge clk);
	endtask

	// Names lean toward ties and shared prefixes so later words decide the order.
	function automatic bit [239:0] pick_name();
		bit [239:0] nm;
		int         len;
		nm = '0;
		case ($urandom_range(0, 3))
			0: begin
				for (int w = 0; w < 8; w++) begin
					nm[30*w +: 30] = 30'($urandom());
				end
			end
			1: begin
				len = $urandom_range(0, 30);
				for (int i = 0; i < len; i++) begin
					nm[239-8*i -: 8] = 8'($urandom_range(1, 255));
				end
			end
			2: begin
				nm = prev_name;
				len = $urandom_range(0, 29);
				nm[239-8*len -: 8] = 8'($urandom_range(0, 255));
			end
			default: begin
				nm = prev_name;
			end
		endcase
		return nm;
	endfunction

	function automatic bit [7:0] pick_age();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(0, 255));
			1: begin
				case ($urandom_range(0, 3))
					0: return 8'd0;
					1: return 8'd1;
					2: return 8'd254;
					default: return 8'd255;
				endcase
			end
			2: return prev_age;
			default: return 8'($urandom_range(20, 23));
		endcase
	endfunction

	always @(posedge clk) begin
		out_item_t want;
		if (srt_if.valid && srt_if.ready) begin
			if (pending_sorted.size() == 0) begin
				flag_error("sorted beat arrived with nothing pending");
			end else begin
				want = pending_sorted.pop_front();
				field_check("original_index", 64'(srt_if.data.original_index),
					64'(want.original_index));
				field_check("sorted_age", 64'(srt_if.data.sorted_age), 64'(want.sorted_age));
				field_check("out_name_a", srt_if.data.out_name_a, want.out_name_a);
				field_check("out_name_b", srt_if.data.out_name_b, want.out_name_b);
				field_check("out_name_c", srt_if.data.out_name_c, want.out_name_c);
				field_check("out_name_d", 64'(srt_if.data.out_name_d), 64'(want.out_name_d));
				field_check("last_result", 64'(srt_if.data.last_result),
					64'(want.last_result));
				field_check("overflow_seen", 64'(srt_if.data.overflow_seen),
					64'(want.overflow_seen));
			end
			results_checked++;
		end
	end

	// Receiver: random stall before each beat, plus one long hold in the middle of a drain.
	initial begin : receiver
		int stall;
		int got;
		bit hold_now;
		bit hold_done;
		got = 0;
		hold_now = 1'b0;
		hold_done = 1'b0;
		srt_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 4);
			if (hold_now) begin
				stall = HOLD_CYCLES;
				hold_now = 1'b0;
			end
			if (stall > 0) begin
				srt_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			srt_if.ready <= 1'b1;
			@(posedge clk);
			while (!srt_if.valid) @(posedge clk);
			got++;
			if (!hold_done && got >= 30 && !srt_if.data.last_result) begin
				hold_now = 1'b1;
				hold_done = 1'b1;
			end
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int         set_len;
		bit [239:0] nm;
		in_item_t   r;
		arst_n       = 1'b0;
		rec_if.valid = 1'b0;
		rec_if.data  = '0;
		stored_cnt   = 0;
		lost_any     = 1'b0;
		no_idle      = 1'b0;
		prev_name    = '0;
		prev_age     = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Single-record sets at the extremes: the result is the record itself.
		plan.push_back('{mk_rec('0, '0, '0, '0, 8'd0, 1'b1), 1'b1,
			mk_res(3'd0, 8'd0, '0, '0, '0, '0, 1'b1, 1'b0)});
		plan.push_back('{mk_rec('1, '1, '1, '1, 8'd255, 1'b1), 1'b1,
			mk_res(3'd0, 8'd255, '1, '1, '1, '1, 1'b1, 1'b0)});
		// Same age throughout: name order, a duplicate key, a difference in the tail
		// word, and a name with a byte after its terminator.
		plan.push_back('{mk_rec(64'h424F_4200_0000_0000, '0, '0, '0, 8'd30, 1'b0), 1'b0, '0});
		plan.push_back('{mk_rec(64'h414C_4943_4500_0000, '0, '0, '0, 8'd30, 1'b0), 1'b0, '0});
		plan.push_back('{mk_rec(64'h424F_4200_0000_0000, '0, '0, '0, 8'd30, 1'b0), 1'b0, '0});
		plan.push_back('{mk_rec(64'h424F_4200_5800_0000, '0, '0, '0, 8'd30, 1'b0), 1'b0, '0});
		plan.push_back('{mk_rec(64'h424F_4200_0000_0000, '0, '0, 48'h1, 8'd30, 1'b1),
			1'b0, '0});
		// Rising ages past capacity: each record lands in front, the last two are
		// dropped, the dropped closing record still starts the run.
		for (int i = 0; i < 10; i++) begin
			plan.push_back('{mk_rec(64'h5200_0000_0000_0000 + 64'(i), 64'(i) << 56, '0, '0,
				8'(i + 1), i == 9), 1'b0, '0});
		end
		plan.push_back('{mk_rec(64'h5A45_4400_0000_0000, 64'h0123_4567_89AB_CDEF,
			64'hFEDC_BA98_7654_3210, 48'h0A0B_0C0D_0E0F, 8'd42, 1'b1), 1'b1,
			mk_res(3'd0, 8'd42, 64'h5A45_4400_0000_0000, 64'h0123_4567_89AB_CDEF,
			64'hFEDC_BA98_7654_3210, 48'h0A0B_0C0D_0E0F, 1'b1, 1'b0)});

		@(negedge clk);
		foreach (plan[i]) begin
			send_rec(plan[i].rec, plan[i].typed, plan[i].want);
		end

		while (recs_sent < plan.size() + RANDOM_RECS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12)
				: $urandom_range(1, 8);
			for (int i = 0; i < set_len; i++) begin
				nm = pick_name();
				r = mk_rec(nm[239:176], nm[175:112], nm[111:48], nm[47:0], pick_age(),
					i == set_len - 1);
				prev_name = nm;
				prev_age  = r.age_years;
				send_rec(r, 1'b0, '0);
			end
		end
		rec_if.valid <= 1'b0;
		no_idle = 1'b0;

		while (pending_sorted.size() > 0) @(posedge clk);
		repeat (DRAIN_GUARD) @(posedge clk);

		$display("sent %0d records in %0d sets, %0d of them over capacity", recs_sent,
			sets_closed, overflow_sets);
		$display("compared %0d sorted beats, %0d mismatches", results_checked, err_cnt);
		if (err_cnt == 0) begin
			$display("tb_record_sorter_age_desc_name_asc: done, clean");
		end else begin
			$display("tb_record_sorter_age_desc_name_asc: done, errors");
		end
		$finish;
	end

endmodule
